@@ src/rrfp_pkg.sv @@
// ============================================================================
// rrfp_pkg - shared types and constants of the radar report frame parser
// Frame markers, buffer limits, the error code set and the result record.
// ============================================================================
package rrfp_pkg;

    // Size of the frame buffer that the framing rules are written against.
    localparam int FRAME_BUFFER_BYTES = 256;

    // Width of the frame byte counter; it never goes above FRAME_BUFFER_BYTES-1.
    localparam int POS_W = $clog2(FRAME_BUFFER_BYTES);

    // Byte positions inside a frame, the header counted from zero.
    localparam logic [POS_W-1:0] POS_HEADER_END = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LEN_LO     = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LEN_HI     = POS_W'(5);
    localparam logic [POS_W-1:0] POS_STATUS     = POS_W'(6);
    localparam logic [POS_W-1:0] POS_DIST_LO    = POS_W'(7);
    localparam logic [POS_W-1:0] POS_DIST_HI    = POS_W'(8);
    localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_BUFFER_BYTES - 1);

    // Longest payload length that the length check accepts.
    localparam logic [15:0] LEN_MAX = 16'(FRAME_BUFFER_BYTES - 8);

    // Header, footer and the fixed overhead of a frame.
    localparam logic [7:0]  HDR_BYTE0    = 8'hF4;
    localparam logic [7:0]  HDR_BYTE1    = 8'hF3;
    localparam logic [7:0]  HDR_BYTE2    = 8'hF2;
    localparam logic [7:0]  HDR_BYTE3    = 8'hF1;
    localparam logic [31:0] FOOTER_WORD  = 32'hF8F7F6F5;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd10;

    localparam logic [15:0] MAX_DIST_RESET = 16'd1000;

    // Status codes that mean someone is present.
    localparam logic [7:0] STATUS_MOVING = 8'd1;
    localparam logic [7:0] STATUS_STILL  = 8'd2;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_OVERFLOW   = 2'd1,
        ERR_BAD_LENGTH = 2'd2,
        ERR_BAD_FOOTER = 2'd3
    } t_frame_err;

    typedef struct packed {
        logic       consumed;
        logic       frame_done;
        t_frame_err frame_error;
        logic       presence;
        logic [7:0] status_code;
        logic [15:0] range_cm;
        logic       distance_update;
    } t_result;

    // Expected header byte for a given match position.
    function automatic logic [7:0] header_byte(input logic [1:0] idx);
        logic [7:0] hb;
        unique case (idx)
            2'd0:    hb = HDR_BYTE0;
            2'd1:    hb = HDR_BYTE1;
            2'd2:    hb = HDR_BYTE2;
            default: hb = HDR_BYTE3;
        endcase
        return hb;
    endfunction

endpackage

@@ src/rrfp_framer.sv @@
// ============================================================================
// rrfp_framer - frame tracking state of the radar report frame parser
// Holds header match, frame collection and published results, and computes
// the result of the byte on its input in the same cycle.
// ============================================================================
module rrfp_framer
    import rrfp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    input  logic [15:0]   i_max_range_cm,
    output t_result       o_result
);

    logic [1:0]       r_hdr_pos,     n_hdr_pos;
    logic             r_collect,     n_collect;
    logic [POS_W-1:0] r_byte_pos,    n_byte_pos;
    logic [7:0]       r_len_lo,      n_len_lo;
    logic [15:0]      r_payload_len, n_payload_len;
    logic [7:0]       r_cap_status,  n_cap_status;
    logic [15:0]      r_cap_dist,    n_cap_dist;
    logic [31:0]      r_tail,        n_tail;
    logic             r_presence,    n_presence;
    logic [15:0]      r_last_dist,   n_last_dist;
    logic [7:0]       r_last_status, n_last_status;

    logic             consumed, done, dupd;
    t_frame_err       err;

    always_comb begin
        n_hdr_pos     = r_hdr_pos;
        n_collect     = r_collect;
        n_byte_pos    = r_byte_pos;
        n_len_lo      = r_len_lo;
        n_payload_len = r_payload_len;
        n_cap_status  = r_cap_status;
        n_cap_dist    = r_cap_dist;
        n_tail        = r_tail;
        n_presence    = r_presence;
        n_last_dist   = r_last_dist;
        n_last_status = r_last_status;
        consumed      = 1'b0;
        done          = 1'b0;
        dupd          = 1'b0;
        err           = ERR_NONE;

        if (!r_collect) begin
            if (i_rx_byte == header_byte(r_hdr_pos)) begin
                consumed = 1'b1;
                if (r_hdr_pos == 2'd3) begin
                    n_collect     = 1'b1;
                    n_byte_pos    = POS_HEADER_END;
                    n_hdr_pos     = 2'd0;
                    n_payload_len = 16'd0;
                    n_tail        = 32'd0;
                end else begin
                    n_hdr_pos = r_hdr_pos + 2'd1;
                end
            end else begin
                // A mismatching byte is not retried as a first header byte.
                n_hdr_pos = 2'd0;
            end
        end else if (r_byte_pos >= POS_LAST) begin
            n_collect     = 1'b0;
            n_byte_pos    = '0;
            n_hdr_pos     = 2'd0;
            n_payload_len = 16'd0;
            err           = ERR_OVERFLOW;
        end else begin
            n_byte_pos = r_byte_pos + POS_W'(1);
            n_tail     = {r_tail[23:0], i_rx_byte};
            consumed   = 1'b1;
            if (r_byte_pos == POS_LEN_LO) begin
                n_len_lo = i_rx_byte;
            end
            if (r_byte_pos == POS_LEN_HI) begin
                n_payload_len = {i_rx_byte, r_len_lo};
            end
            if (r_byte_pos == POS_STATUS) begin
                n_cap_status = i_rx_byte;
            end
            if (r_byte_pos == POS_DIST_LO) begin
                n_cap_dist = {8'd0, i_rx_byte};
            end
            if (r_byte_pos == POS_DIST_HI) begin
                n_cap_dist = {i_rx_byte, r_cap_dist[7:0]};
            end

            if (r_byte_pos == POS_LEN_HI && n_payload_len > LEN_MAX) begin
                n_collect     = 1'b0;
                n_byte_pos    = '0;
                n_hdr_pos     = 2'd0;
                n_payload_len = 16'd0;
                consumed      = 1'b0;
                err           = ERR_BAD_LENGTH;
            end else if (17'(n_byte_pos) >= FRAME_OVERHEAD + 17'(n_payload_len)) begin
                if (n_tail == FOOTER_WORD) begin
                    done          = 1'b1;
                    n_last_status = n_cap_status;
                    n_presence    = (n_cap_status == STATUS_MOVING) ||
                                    (n_cap_status == STATUS_STILL);
                    if (n_cap_dist != 16'd0 && n_cap_dist <= i_max_range_cm) begin
                        n_last_dist = n_cap_dist;
                        dupd        = 1'b1;
                    end
                end else begin
                    err = ERR_BAD_FOOTER;
                end
                n_collect     = 1'b0;
                n_byte_pos    = '0;
                n_hdr_pos     = 2'd0;
                n_payload_len = 16'd0;
            end
        end

        o_result.consumed        = consumed;
        o_result.frame_done      = done;
        o_result.frame_error     = err;
        o_result.presence        = n_presence;
        o_result.status_code     = n_last_status;
        o_result.range_cm        = n_last_dist;
        o_result.distance_update = dupd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos     <= 2'd0;
            r_collect     <= 1'b0;
            r_byte_pos    <= '0;
            r_len_lo      <= 8'd0;
            r_payload_len <= 16'd0;
            r_cap_status  <= 8'd0;
            r_cap_dist    <= 16'd0;
            r_tail        <= 32'd0;
            r_presence    <= 1'b0;
            r_last_dist   <= 16'd0;
            r_last_status <= 8'd0;
        end else if (i_accept) begin
            r_hdr_pos     <= n_hdr_pos;
            r_collect     <= n_collect;
            r_byte_pos    <= n_byte_pos;
            r_len_lo      <= n_len_lo;
            r_payload_len <= n_payload_len;
            r_cap_status  <= n_cap_status;
            r_cap_dist    <= n_cap_dist;
            r_tail        <= n_tail;
            r_presence    <= n_presence;
            r_last_dist   <= n_last_dist;
            r_last_status <= n_last_status;
        end
    end

endmodule

@@ src/radar_report_frame_parser.sv @@
// ============================================================================
// radar_report_frame_parser - binary report frame parser for a radar sensor
// Finds header/length/payload/footer frames in a byte stream and publishes
// presence, status and distance from each good frame.
// ============================================================================
// One received byte enters per item and produces exactly one registered
// result item, so the block sustains one byte per clock cycle. All
// framing decisions for a byte are made in a single pass of logic between the
// frame tracking registers and the result register; the only thing that
// slows the stream is the downstream side holding i_stall. The result
// register frees itself in the same cycle it is taken, so a new byte is
// accepted while the previous result is being handed over. The distance
// limit register resets to 1000 and should only be written while no byte
// result is still pending.
// ============================================================================
module radar_report_frame_parser
    import rrfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration: distance limit in centimeters.
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,

    // Byte input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,

    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_consumed,
    output logic        o_frame_done,
    output logic [1:0]  o_frame_error,
    output logic        o_presence,
    output logic [7:0]  o_status_code,
    output logic [15:0] o_range_cm,
    output logic        o_distance_update
);

    logic [15:0] r_max_dist;
    logic        r_out_valid;
    t_result     r_out;
    t_result     step_result;
    logic        accept;

    // The input stalls only when a result is held and the consumer refuses it.
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    // Frame tracking state and the per-byte decision logic.
    rrfp_framer u_framer (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_rx_byte         (i_rx_byte),
        .i_max_range_cm    (r_max_dist),
        .o_result          (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= MAX_DIST_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_dist <= i_cfg_wr_data;
        end
    end

    // Result register: loaded on every accepted byte, drained by the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= step_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_consumed        = r_out.consumed;
    assign o_frame_done      = r_out.frame_done;
    assign o_frame_error     = r_out.frame_error;
    assign o_presence        = r_out.presence;
    assign o_status_code     = r_out.status_code;
    assign o_range_cm        = r_out.range_cm;
    assign o_distance_update = r_out.distance_update;

endmodule
